@@ hw/rtl/bci_pkg.sv @@
// Package for the breakpoint curve interpolator: request codes, payload structs,
// default parameter values. No dependencies.
package bci_pkg;

  localparam int NUM_POINTS_DEF   = 11;
  localparam int NOTE_SPACING_DEF = 6;

  localparam logic [1:0] REQ_FILL   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_LOOKUP = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         index;
    logic signed [31:0] new_value;
    logic [5:0]         note;
  } bci_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               point_is_set;
  } bci_out_t;

endpackage

@@ hw/rtl/breakpoint_curve_interpolator_top.sv @@
// Breakpoint curve interpolator top level: point store, sequencer, serial divider.
// Depends on bci_pkg.
//
// Usage: drive in_req and raise start while busy is low; the request is taken at
// that edge and busy rises. One result comes back on out_result with out_valid
// high for one cycle; busy is already low in that cycle, so the next request can
// be taken at the same edge as the result.
// Fill writes every point in turn. Lookup splits the note into a point and an
// offset by repeated subtraction, then runs the shared restoring divider, one
// quotient bit per cycle. Set and clear scan for the neighbor marks one point
// per cycle, then each rewritten point goes through the divider in turn; an
// ignored set or clear goes straight to the result. One request at a time: a
// new request is taken only when busy is low again.
// Reset sets all points to zero with only the default point marked; the store
// is cleared by a sweep over all points during which busy is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module breakpoint_curve_interpolator_top
  import bci_pkg::*;
#(
  parameter int NUM_POINTS   = NUM_POINTS_DEF,
  parameter int NOTE_SPACING = NOTE_SPACING_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bci_in_t  in_req,
  output logic     out_valid,
  output bci_out_t out_result
);

  localparam int IW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int SW = $clog2(NOTE_SPACING + 1) + 1;
  localparam int CW = (IW + 1 > SW) ? IW + 1 : SW;
  localparam int DEF_MARK = (NUM_POINTS > 4) ? 4 : NUM_POINTS - 1;
  localparam int TOP_NOTE = (NUM_POINTS - 1) * NOTE_SPACING;
  localparam int NW = $clog2(TOP_NOTE + 1) + 1;
  localparam int DW = 33 + CW;
  localparam int QW = 6;

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_FILL   = 10'b0000000100,
    S_SCANL  = 10'b0000001000,
    S_SCANR  = 10'b0000010000,
    S_PREP   = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_WRITE  = 10'b0010000000,
    S_DONE   = 10'b0100000000,
    S_NOTE   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_RIGHT = 2'd1,
    PH_SPAN  = 2'd2,
    PH_LOOK  = 2'd3
  } phase_t;

  logic signed [31:0] mem [NUM_POINTS];
  logic [NUM_POINTS-1:0] mask_r, mask_nxt;
  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  bci_in_t req_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic          lo_ok_r, lo_ok_nxt;
  logic          hi_ok_r, hi_ok_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [31:0] b_r, b_nxt;
  logic [CW-1:0] num_r, num_nxt;
  logic [CW-1:0] den_r, den_nxt;
  logic [QW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  logic [NW-1:0] nrem_r, nrem_nxt;
  logic          we;
  logic [IW-1:0] waddr;
  logic signed [31:0] wdata;
  logic          out_valid_r;
  bci_out_t      out_r, out_nxt;

  logic          idx_ok;
  logic [IW-1:0] idx;
  logic [NW-1:0] note_sat;
  logic signed [32:0] diff;
  logic [DW-1:0] prod;
  logic [DW:0]   trial;
  logic signed [32:0] quo_s;
  logic signed [32:0] sum;

  assign idx_ok = {2'b00, req_r.index} < 6'(NUM_POINTS);
  assign idx    = IW'(req_r.index);

  assign note_sat = (32'(in_req.note) > 32'(TOP_NOTE)) ? NW'(TOP_NOTE) : NW'(in_req.note);

  assign diff  = 33'(b_r) - 33'(a_r);
  assign trial = {rem_r, quo_r[DW-1]} - {1'b0, {(DW-CW){1'b0}}, den_r};
  assign quo_s = neg_r ? -33'(quo_r[32:0]) : 33'(quo_r[32:0]);
  assign sum   = 33'(a_r) + quo_s;

  always_comb begin
    logic [32:0] mag;
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    prod = DW'(mag) * DW'(num_r);
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    ptr_nxt   = ptr_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    lo_ok_nxt = lo_ok_r;
    hi_ok_nxt = hi_ok_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    nrem_nxt  = nrem_r;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = ptr_r[IW-1:0];
    wdata     = a_r;
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        wdata = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(NUM_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ptr_nxt = '0;
          nrem_nxt = note_sat;
          case (in_req.req_type)
            REQ_FILL: state_nxt = S_FILL;
            REQ_LOOKUP: state_nxt = S_NOTE;
            default: state_nxt = S_SCANL;
          endcase
          phase_nxt = PH_LOOK;
        end
      end
      S_NOTE: begin
        // split the note into point and offset by repeated subtraction
        if (nrem_r >= NW'(NOTE_SPACING)) begin
          nrem_nxt = nrem_r - NW'(NOTE_SPACING);
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_FILL: begin
        we = 1'b1;
        wdata = req_r.new_value;
        mask_nxt = '0;
        mask_nxt[DEF_MARK] = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(NUM_POINTS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_SCANL: begin
        // entry: prepare mask change, then find lower marked neighbor
        if (!idx_ok) begin
          state_nxt = S_DONE;
        end else if (req_r.req_type == REQ_CLEAR &&
                     (!mask_r[idx] || mask_r == (NUM_POINTS'(1) << idx))) begin
          state_nxt = S_DONE;
        end else begin
          mask_nxt = mask_r;
          mask_nxt[idx] = (req_r.req_type == REQ_SET);
          if (req_r.req_type == REQ_SET) begin
            we = 1'b1;
            waddr = idx;
            wdata = req_r.new_value;
          end
          lo_ok_nxt = 1'b0;
          hi_ok_nxt = 1'b0;
          lo_nxt = '0;
          hi_nxt = CW'(NUM_POINTS - 1);
          ptr_nxt = CW'(idx);
          state_nxt = S_SCANR;
          phase_nxt = PH_LEFT;
        end
      end
      S_SCANR: begin
        // walk one point per cycle: left down from idx, then right up from idx
        if (phase_r == PH_LEFT) begin
          if (ptr_r == '0) begin
            ptr_nxt = CW'(idx);
            phase_nxt = PH_RIGHT;
          end else if (mask_r[ptr_r[IW-1:0] - 1'b1]) begin
            lo_nxt = ptr_r - 1'b1;
            lo_ok_nxt = 1'b1;
            ptr_nxt = CW'(idx);
            phase_nxt = PH_RIGHT;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end else begin
          if (ptr_r == CW'(NUM_POINTS - 1)) begin
            phase_nxt = PH_SPAN;
            state_nxt = S_PREP;
            ptr_nxt = lo_r;
          end else if (mask_r[ptr_r[IW-1:0] + 1'b1]) begin
            hi_nxt = ptr_r + 1'b1;
            hi_ok_nxt = 1'b1;
            phase_nxt = PH_SPAN;
            state_nxt = S_PREP;
            ptr_nxt = lo_r;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end
      S_PREP: begin
        // pick endpoints for the next point to write, or for the lookup result
        if (phase_r == PH_LOOK) begin
          a_nxt = mem[ptr_r[IW-1:0]];
          b_nxt = (nrem_r == '0) ? mem[ptr_r[IW-1:0]] : mem[ptr_r[IW-1:0] + 1'b1];
          num_nxt = CW'(nrem_r);
          den_nxt = CW'(NOTE_SPACING);
          state_nxt = S_DIV;
          cnt_nxt = '0;
        end else if (ptr_r > hi_r || ptr_r == hi_r && hi_ok_r) begin
          state_nxt = S_DONE;
        end else if ((ptr_r == lo_r && lo_ok_r) ||
                     (req_r.req_type == REQ_SET && ptr_r == CW'(idx))) begin
          ptr_nxt = ptr_r + 1'b1;
        end else if (req_r.req_type == REQ_SET) begin
          // set: interpolate from the new point out to the neighbor on this side
          a_nxt = mem[idx];
          if (ptr_r < CW'(idx)) begin
            b_nxt = lo_ok_r ? mem[lo_r[IW-1:0]] : mem[idx];
            num_nxt = lo_ok_r ? CW'(idx) - ptr_r : '0;
            den_nxt = lo_ok_r ? CW'(idx) - lo_r : CW'(1);
          end else begin
            b_nxt = hi_ok_r ? mem[hi_r[IW-1:0]] : mem[idx];
            num_nxt = hi_ok_r ? ptr_r - CW'(idx) : '0;
            den_nxt = hi_ok_r ? hi_r - CW'(idx) : CW'(1);
          end
          state_nxt = S_DIV;
          cnt_nxt = '0;
        end else if (lo_ok_r && hi_ok_r) begin
          a_nxt = mem[lo_r[IW-1:0]];
          b_nxt = mem[hi_r[IW-1:0]];
          num_nxt = ptr_r - lo_r;
          den_nxt = hi_r - lo_r;
          state_nxt = S_DIV;
          cnt_nxt = '0;
        end else begin
          a_nxt = lo_ok_r ? mem[lo_r[IW-1:0]] :
                  hi_ok_r ? mem[hi_r[IW-1:0]] : mem[idx];
          b_nxt = a_nxt;
          num_nxt = '0;
          den_nxt = CW'(1);
          state_nxt = S_DIV;
          cnt_nxt = '0;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          rem_nxt = '0;
          quo_nxt = prod;
          neg_nxt = diff[32];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (!trial[DW]) begin
            rem_nxt = trial[DW-1:0];
          end else begin
            rem_nxt = {rem_r[DW-2:0], quo_r[DW-1]};
          end
          quo_nxt = {quo_r[DW-2:0], !trial[DW]};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == QW'(DW)) begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (phase_r == PH_LOOK) begin
          out_nxt.result_value = 32'(sum);
          out_nxt.point_is_set = idx_ok ? mask_r[idx] : 1'b0;
          state_nxt = S_IDLE;
        end else begin
          we = 1'b1;
          wdata = 32'(sum);
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        out_nxt.result_value = idx_ok ? mem[idx] : '0;
        out_nxt.point_is_set = idx_ok ? mask_r[idx] : 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      phase_r <= PH_LOOK;
      mask_r  <= NUM_POINTS'(1) << DEF_MARK;
      ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      ptr_r   <= ptr_nxt;
      out_valid_r <= (state_r == S_DONE) ||
                     (state_r == S_WRITE && phase_r == PH_LOOK);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_req;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    lo_ok_r <= lo_ok_nxt;
    hi_ok_r <= hi_ok_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    nrem_r <= nrem_nxt;
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without busy");
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r != '0)
    else $error("breakpoint mask empty");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> den_r != '0)
    else $error("zero divisor");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Testbench for breakpoint_curve_interpolator_top: random and directed requests,
// checked against an in-bench curve predictor. Depends on bci_pkg.
module tb
  import bci_pkg::*;
();

  localparam int NP = NUM_POINTS_DEF;
  localparam int NS = NOTE_SPACING_DEF;
  localparam int DEF_MARK = (NP > 4) ? 4 : NP - 1;
  localparam int LIMIT = 2000000;

  class curve_scoreboard;
    logic signed [31:0] pts[NP];
    logic [NP-1:0] marks;
    bci_out_t pending[$];
    int errors;

    function new();
      errors = 0;
      fill(32'sd0);
    endfunction

    function void fill(logic signed [31:0] v);
      for (int i = 0; i < NP; i++) pts[i] = v;
      marks = '0;
      marks[DEF_MARK] = 1'b1;
    endfunction

    function logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                       int p, int q);
      longint d;
      d = longint'(b) - longint'(a);
      return 32'(longint'(a) + (d * p) / q);
    endfunction

    function void set_pt(int idx, logic signed [31:0] v);
      int j;
      pts[idx] = v;
      marks[idx] = 1'b1;
      j = idx - 1;
      while (j >= 0 && !marks[j]) j--;
      for (int i = j + 1; i < idx; i++)
        pts[i] = (j < 0) ? v : blend(v, pts[j], idx - i, idx - j);
      j = idx + 1;
      while (j < NP && !marks[j]) j++;
      for (int i = idx + 1; i < j; i++)
        pts[i] = (j >= NP) ? v : blend(v, pts[j], i - idx, j - idx);
    endfunction

    function void clear_pt(int idx);
      int j, k;
      logic [NP-1:0] m;
      m = '0;
      m[idx] = 1'b1;
      if (!marks[idx] || marks == m) return;
      marks[idx] = 1'b0;
      j = idx - 1;
      while (j >= 0 && !marks[j]) j--;
      k = idx + 1;
      while (k < NP && !marks[k]) k++;
      if (j >= 0 && k < NP) begin
        for (int i = j + 1; i < k; i++) pts[i] = blend(pts[j], pts[k], i - j, k - j);
      end else if (j >= 0) begin
        for (int i = j + 1; i < NP; i++) pts[i] = pts[j];
      end else if (k < NP) begin
        for (int i = 0; i < k; i++) pts[i] = pts[k];
      end
    endfunction

    function logic signed [31:0] sample(int note);
      int n, i, k;
      n = (note > (NP - 1) * NS) ? (NP - 1) * NS : note;
      i = n / NS;
      k = n % NS;
      if (k == 0 || i + 1 >= NP) return pts[i];
      return blend(pts[i], pts[i + 1], k, NS);
    endfunction

    function void note_request(bci_in_t r);
      bci_out_t e;
      bit ok;
      ok = r.index < NP;
      case (r.req_type)
        REQ_FILL: fill(r.new_value);
        REQ_SET: if (ok) set_pt(r.index, r.new_value);
        REQ_CLEAR: if (ok) clear_pt(r.index);
        default: ;
      endcase
      e.result_value = 0;
      if (r.req_type == REQ_LOOKUP) e.result_value = sample(r.note);
      else if (ok) e.result_value = pts[r.index];
      e.point_is_set = ok ? marks[r.index] : 1'b0;
      pending.push_back(e);
    endfunction

    function void check(bci_out_t got);
      bci_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.result_value !== e.result_value || got.point_is_set !== e.point_is_set) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %h set %b, got value %h set %b",
                   e.result_value, e.point_is_set, got.result_value, got.point_is_set);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  bci_in_t in_req;
  bci_out_t out_result;
  curve_scoreboard sb;
  int cycles = 0;
  int idle_pct;

  breakpoint_curve_interpolator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid) sb.check(out_result);
  end

  task automatic send(logic [1:0] t, logic [3:0] idx, logic signed [31:0] v, logic [5:0] nt);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_req <= '{req_type: t, index: idx, new_value: v, note: nt};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(in_req);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(7) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int r;
    logic [3:0] idx;
    r = $urandom_range(99);
    idx = ($urandom_range(19) == 0) ? 4'($urandom_range(15, NP)) : 4'($urandom_range(NP - 1));
    if (r < 4) send(REQ_FILL, 4'($urandom), rand_value(), 6'($urandom));
    else if (r < 40) send(REQ_SET, idx, rand_value(), 6'($urandom));
    else if (r < 65) send(REQ_CLEAR, idx, rand_value(), 6'($urandom));
    else send(REQ_LOOKUP, 4'($urandom), rand_value(), 6'($urandom));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(REQ_LOOKUP, 4'd4, 32'sd0, 6'd63);
    send(REQ_CLEAR, 4'd4, 32'sd0, 6'd0);
    send(REQ_CLEAR, 4'd3, 32'sd0, 6'd0);
    send(REQ_SET, 4'd0, 32'sh7fffffff, 6'd0);
    send(REQ_SET, 4'd10, 32'sh80000000, 6'd0);
    for (int n = 0; n < 64; n += 7) send(REQ_LOOKUP, 4'd15, 32'sd0, 6'(n));
    send(REQ_LOOKUP, 4'd0, 32'sd0, 6'd63);
    send(REQ_SET, 4'd15, 32'sd5, 6'd0);
    send(REQ_CLEAR, 4'd11, 32'sd0, 6'd0);
    send(REQ_CLEAR, 4'd4, 32'sd0, 6'd0);
    send(REQ_CLEAR, 4'd0, 32'sd0, 6'd0);
    send(REQ_CLEAR, 4'd10, 32'sd0, 6'd0);
    send(REQ_FILL, 4'd12, 32'shffffffff, 6'd0);
    send(REQ_SET, 4'd7, 32'sh00010000, 6'd0);
    send(REQ_LOOKUP, 4'd0, 32'sd0, 6'd45);
    drain();
    for (int i = 0; i < 650; i++) begin
      idle_pct = (i < 220) ? 7 : (i < 440) ? 76 : 0;
      random_request();
      if (i == 300) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ breakpoint_curve_interpolator_top.f @@
hw/rtl/bci_pkg.sv
hw/rtl/breakpoint_curve_interpolator_top.sv
tb/sv/tb.sv
